// ===== hdl/bis_pkg.sv =====
`default_nettype none
package bis_pkg;

  // Store size and field widths.
  localparam int CAPACITY     = 64;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 16;

  // Fill count must hold the value CAPACITY itself.
  localparam int FILL_BITS = $clog2(CAPACITY + 1);

  // Stream data width: key and payload packed, padded to whole bytes.
  localparam int REC_BITS   = KEY_BITS + PAYLOAD_BITS;
  localparam int TDATA_BITS = ((REC_BITS + 7) / 8) * 8;

  // Controller states.
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } bis_state_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert the broadcast record
    logic pop;  // shift the chain one place toward cell zero
  } bis_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/bis_cell.sv =====
`default_nettype none
module bis_cell
  import bis_pkg::*;
(
  input  wire logic                           clk,
  input  wire bis_ctrl_t                      ctrl,
  input  wire logic                           occ,
  input  wire logic signed [KEY_BITS-1:0]     new_key,
  input  wire logic        [PAYLOAD_BITS-1:0] new_payload,
  input  wire logic                           left_gt,
  input  wire logic signed [KEY_BITS-1:0]     left_key,
  input  wire logic        [PAYLOAD_BITS-1:0] left_payload,
  input  wire logic signed [KEY_BITS-1:0]     right_key,
  input  wire logic        [PAYLOAD_BITS-1:0] right_payload,
  output logic                                gt,
  output logic signed [KEY_BITS-1:0]          key,
  output logic        [PAYLOAD_BITS-1:0]      payload
);

  logic signed [KEY_BITS-1:0]     key_next;
  logic        [PAYLOAD_BITS-1:0] payload_next;

  // An empty cell counts as greater, so the new record lands at the first free cell.
  assign gt = !occ || (key > new_key);

  // Insert shifts the greater part of the chain up by one; pop shifts everything down.
  always_comb begin
    key_next     = key;
    payload_next = payload;
    if (ctrl.ins && gt) begin
      if (left_gt) begin
        key_next     = left_key;
        payload_next = left_payload;
      end else begin
        key_next     = new_key;
        payload_next = new_payload;
      end
    end else if (ctrl.pop) begin
      key_next     = right_key;
      payload_next = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    payload <= payload_next;
  end

endmodule
`default_nettype wire

// ===== hdl/binary_insertion_sorter.sv =====
// Stable ascending sorter for records of a signed key and an opaque payload.
// Input stream (s_*): one record per transfer, s_tlast marks the final record
// of a set. While a set is loading, s_tready stays high and one record is
// taken every cycle; each record is placed into a chain of cells in the same
// cycle by a parallel compare of its key against every stored key. A record
// goes after any stored record with an equal key.
// Output stream (m_*): the cycle after the transfer carrying s_tlast, the
// stored records are presented in ascending order, one per cycle while
// m_tready is high, taken from the head of the chain as it shifts down. The
// last one carries m_tlast. m_tuser is high on every record of a set in which
// records were dropped because the chain was full.
// No input is taken while a set is being emitted. When the receiver stalls,
// the head record holds and the chain does not move.
// Reset empties the chain and clears the dropped flag; the block then waits
// for the first record of a set.
`default_nettype none
module binary_insertion_sorter
  import bis_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [TDATA_BITS-1:0] s_tdata,   // key, payload, zero padding
  input  wire logic                  s_tlast,   // last_in
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [TDATA_BITS-1:0] m_tdata,   // sorted_key, sorted_payload, zero padding
  output logic                       m_tlast,   // last_out
  output logic                       m_tuser    // overflow
);

  bis_state_t             state;
  bis_state_t             state_next;
  logic [FILL_BITS-1:0]   fill;
  logic [FILL_BITS-1:0]   fill_next;
  logic                   dropped;
  logic                   dropped_next;
  bis_ctrl_t              ctrl;
  logic                   in_xfer;
  logic                   out_xfer;
  logic                   full;

  logic signed [KEY_BITS-1:0]     new_key;
  logic        [PAYLOAD_BITS-1:0] new_payload;

  logic        [CAPACITY-1:0]     occ;
  logic        [CAPACITY-1:0]     gt;
  logic signed [KEY_BITS-1:0]     cell_key     [CAPACITY];
  logic        [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];

  // Unpack the input record.
  assign new_key     = s_tdata[KEY_BITS-1:0];
  assign new_payload = s_tdata[REC_BITS-1:KEY_BITS];

  // Handshakes.
  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_EMIT);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign full     = (fill == FILL_BITS'(CAPACITY));

  // Chain commands.
  assign ctrl.ins = in_xfer && !full;
  assign ctrl.pop = out_xfer;

  // Output record comes straight from the head cell.
  assign m_tdata = {{(TDATA_BITS - REC_BITS){1'b0}}, cell_payload[0], cell_key[0]};
  assign m_tlast = (fill == FILL_BITS'(1));
  assign m_tuser = dropped;

  // Chain of cells; cell i is occupied when it lies below the fill count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                           l_gt;
    logic signed [KEY_BITS-1:0]     l_key;
    logic        [PAYLOAD_BITS-1:0] l_payload;
    logic signed [KEY_BITS-1:0]     r_key;
    logic        [PAYLOAD_BITS-1:0] r_payload;

    assign occ[i] = (FILL_BITS'(i) < fill);

    if (i == 0) begin : g_head
      assign l_gt      = 1'b0;
      assign l_key     = new_key;
      assign l_payload = new_payload;
    end else begin : g_body
      assign l_gt      = gt[i-1];
      assign l_key     = cell_key[i-1];
      assign l_payload = cell_payload[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key     = cell_key[i];
      assign r_payload = cell_payload[i];
    end else begin : g_mid
      assign r_key     = cell_key[i+1];
      assign r_payload = cell_payload[i+1];
    end

    bis_cell u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .occ           (occ[i]),
      .new_key       (new_key),
      .new_payload   (new_payload),
      .left_gt       (l_gt),
      .left_key      (l_key),
      .left_payload  (l_payload),
      .right_key     (r_key),
      .right_payload (r_payload),
      .gt            (gt[i]),
      .key           (cell_key[i]),
      .payload       (cell_payload[i])
    );
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      fill    <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      dropped <= dropped_next;
    end
  end

  // Next state: load until the last record, then drain the chain.
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    dropped_next = dropped;
    case (state)
      ST_LOAD: begin
        if (in_xfer) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            fill_next = fill + FILL_BITS'(1);
          end
          if (s_tlast) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          fill_next = fill - FILL_BITS'(1);
          if (m_tlast) begin
            dropped_next = 1'b0;
            state_next   = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // The two sides never run at once.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output active together");

  // The fill count never passes the chain length.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_BITS'(CAPACITY))
    else $error("fill count beyond capacity");

  // A record taken while full is counted as dropped.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && full) |=> dropped)
    else $error("dropped record not flagged");

  // Emitting the final record empties the chain and clears the flag.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_tlast) |=> (fill == '0 && !dropped && state == ST_LOAD))
    else $error("chain not empty after final record");

  // Emission never runs on an empty chain.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (fill != '0))
    else $error("emitting from an empty chain");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import bis_pkg::*;

  // One record as it travels on the input stream.
  typedef struct {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    last;
  } record_t;

  // One sorted record as it should appear on the output stream.
  typedef struct {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    last;
    logic                    overflow;
  } sorted_t;

  localparam logic [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
  localparam logic [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
  localparam logic [KEY_BITS-1:0] KEY_NEG1 = '1;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] s_tdata = '0;   // key, payload, zero padding
  logic                  s_tlast = 1'b0; // last_in
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;        // sorted_key, sorted_payload, zero padding
  logic                  m_tlast;        // last_out
  logic                  m_tuser;        // overflow

  // Records waiting to be driven, the sorted set being built, and the
  // sorted records expected on the output.
  record_t input_backlog[$];
  record_t sorted_store[$];
  sorted_t expected_sorted[$];
  logic    set_dropped = 1'b0;

  record_t drive_rec;
  logic    in_taken = 1'b0;
  int      sender_idle_pct = 24;
  int      receiver_idle_pct = 87;
  int      error_count = 0;
  int      quiet_cycles = 0;

  binary_insertion_sorter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Insert a record after every stored record with an equal or smaller key;
  // a record marked last releases the whole set in order.
  task automatic absorb_record(input record_t rec);
    int      lo;
    int      hi;
    int      mid;
    int      n;
    sorted_t res;
    lo = 0;
    hi = sorted_store.size();
    if (sorted_store.size() < CAPACITY) begin
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if ($signed(sorted_store[mid].key) > $signed(rec.key)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      sorted_store.insert(lo, rec);
    end else begin
      set_dropped = 1'b1;
    end
    if (rec.last) begin
      n = sorted_store.size();
      for (int i = 0; i < n; i++) begin
        res.key      = sorted_store[i].key;
        res.payload  = sorted_store[i].payload;
        res.last     = (i == n - 1);
        res.overflow = set_dropped;
        expected_sorted.push_back(res);
      end
      sorted_store.delete();
      set_dropped = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp,
                             input logic [63:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
      error_count++;
    end
  endtask

  task automatic push_record(input logic [KEY_BITS-1:0] key,
                             input logic [PAYLOAD_BITS-1:0] payload,
                             input logic last);
    record_t rec;
    rec.key     = key;
    rec.payload = payload;
    rec.last    = last;
    input_backlog.push_back(rec);
  endtask

  // Half full-range keys, often a narrow band to force ties, some extremes.
  function automatic logic [KEY_BITS-1:0] random_key();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      return $urandom;
    end else if (pick < 17) begin
      return KEY_BITS'($urandom_range(0, 6) - 3);
    end else begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return '0;
        default: return KEY_NEG1;
      endcase
    end
  endfunction

  task automatic push_set(input int len);
    for (int i = 0; i < len; i++) begin
      push_record(random_key(), PAYLOAD_BITS'($urandom), i == len - 1);
    end
  endtask

  // Sets are mostly short, sometimes medium, rarely close to capacity.
  task automatic push_random_sets(input int budget);
    int count;
    int pick;
    int len;
    count = 0;
    while (count < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 8);
      end else if (pick < 95) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(41, CAPACITY);
      end
      push_set(len);
      count += len;
    end
  endtask

  // Driver: input transfers and receiver backpressure change at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || in_taken) begin
        if (input_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          drive_rec = input_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= TDATA_BITS'({drive_rec.payload, drive_rec.key});
          s_tlast  <= drive_rec.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Monitor: sample both streams at the rising edge.
  always @(posedge clk) begin
    sorted_t exp;
    record_t rec;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        rec.key     = s_tdata[KEY_BITS-1:0];
        rec.payload = s_tdata[KEY_BITS +: PAYLOAD_BITS];
        rec.last    = s_tlast;
        absorb_record(rec);
      end
      if (m_tvalid && m_tready) begin
        if (expected_sorted.size() == 0) begin
          $display("%0t: unexpected output transfer, expected none actual %h",
                   $time, m_tdata);
          error_count++;
        end else begin
          exp = expected_sorted.pop_front();
          check_field("sorted_key", 64'(exp.key), 64'(m_tdata[KEY_BITS-1:0]));
          check_field("sorted_payload", 64'(exp.payload),
                      64'(m_tdata[KEY_BITS +: PAYLOAD_BITS]));
          check_field("last_out", 64'(exp.last), 64'(m_tlast));
          check_field("overflow", 64'(exp.overflow), 64'(m_tuser));
        end
      end
    end
  end

  // Watchdog: give up when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int big_len[3];
    big_len = '{CAPACITY + 1, CAPACITY, CAPACITY + 4};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A set of one record at the top of the key range.
    push_record(KEY_MAX, 16'hFFFF, 1'b1);
    // Extremes, ties kept in arrival order, payload extremes.
    push_record(KEY_MIN, 16'h0000, 1'b0);
    push_record(KEY_MAX, 16'h1234, 1'b0);
    push_record(32'sd7, 16'h0001, 1'b0);
    push_record('0, 16'hAAAA, 1'b0);
    push_record(KEY_NEG1, 16'h5555, 1'b0);
    push_record(32'sd7, 16'h0002, 1'b0);
    push_record(32'sd1, 16'hFFFF, 1'b0);
    push_record(KEY_MIN, 16'h8000, 1'b0);
    push_record(32'sd7, 16'h0003, 1'b0);
    push_record(KEY_MAX, 16'h7FFF, 1'b0);
    push_record(KEY_NEG1, 16'h0F0F, 1'b1);
    // Two equal minimum keys.
    push_record(KEY_MIN, 16'h0000, 1'b0);
    push_record(KEY_MIN, 16'hFFFF, 1'b1);
    // Descending keys.
    push_record(32'sd100, 16'h0010, 1'b0);
    push_record(32'sd50, 16'h0020, 1'b0);
    push_record('0, 16'h0030, 1'b0);
    push_record(-32'sd50, 16'h0040, 1'b0);
    push_record(-32'sd100, 16'h0050, 1'b1);

    // Three idling profiles; each includes a set at or beyond capacity,
    // including two whose last record is itself dropped.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct   = 24;
          receiver_idle_pct = 87;
        end
        1: begin
          sender_idle_pct   = 87;
          receiver_idle_pct = 24;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      push_set(big_len[ph]);
      push_random_sets(25);
      while (input_backlog.size() != 0) @(posedge clk);
    end

    // Wait for the last input transfer, then for all sorted output.
    while (input_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_sorted.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bis_pkg.sv
hdl/bis_cell.sv
hdl/binary_insertion_sorter.sv
test/tb_top.sv
